// ----- rtl/core/twps_pkg.sv -----
`timescale 1ns / 1ps

package twps_pkg;

    localparam int WORD_WIDTH    = 32;
    localparam int FRACTION_BITS = 16;
    localparam int CFG_W         = WORD_WIDTH - 1;
    localparam int ENERGY_W      = 48;
    localparam int CFG_IDX_W     = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_BOX_LENGTH    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP     = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_PARTICLE_MASS = CFG_IDX_W'(2);

    localparam logic [CFG_W-1:0] BOX_LENGTH_RESET = CFG_W'(100 << FRACTION_BITS);
    localparam logic [CFG_W-1:0] TIME_STEP_RESET  = CFG_W'(((1 << FRACTION_BITS) + 5) / 10);
    localparam logic [CFG_W-1:0] MASS_RESET       = CFG_W'(1 << FRACTION_BITS);

    localparam logic [ENERGY_W-1:0] ENERGY_MAX = {ENERGY_W{1'b1}};

    localparam int DIV_STEPS = WORD_WIDTH + FRACTION_BITS;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    typedef struct packed {
        logic [CFG_W-1:0] box_length;
        logic [CFG_W-1:0] time_step;
        logic [CFG_W-1:0] particle_mass;
    } cfg_t;

    typedef struct packed {
        logic                  done;
        logic                  ovf;
        logic [WORD_WIDTH-1:0] quot;
    } div_res_t;

    function automatic logic [WORD_WIDTH-1:0] mag_f(input logic [WORD_WIDTH-1:0] a);
        return a[WORD_WIDTH-1] ? (~a + 1'b1) : a;
    endfunction

endpackage

// ----- rtl/core/twps_cfg_if.sv -----
`timescale 1ns / 1ps

interface twps_cfg_if import twps_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/twps_in_if.sv -----
`timescale 1ns / 1ps

interface twps_in_if import twps_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic signed [WORD_WIDTH-1:0] old_position;
    logic signed [WORD_WIDTH-1:0] old_velocity;
    logic signed [WORD_WIDTH-1:0] left_sample;
    logic signed [WORD_WIDTH-1:0] right_sample;
    logic                         last_particle;

    modport source (output valid, output old_position, output old_velocity,
                    output left_sample, output right_sample, output last_particle,
                    input ready);
    modport sink   (input valid, input old_position, input old_velocity,
                    input left_sample, input right_sample, input last_particle,
                    output ready);
endinterface

// ----- rtl/core/twps_out_if.sv -----
`timescale 1ns / 1ps

interface twps_out_if import twps_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic signed [WORD_WIDTH-1:0] new_position;
    logic signed [WORD_WIDTH-1:0] new_velocity;
    logic                         hit_left;
    logic                         hit_right;
    logic [ENERGY_W-1:0]          energy_total;
    logic                         energy_final;

    modport source (output valid, output new_position, output new_velocity,
                    output hit_left, output hit_right, output energy_total,
                    output energy_final, input ready);
    modport sink   (input valid, input new_position, input new_velocity,
                    input hit_left, input hit_right, input energy_total,
                    input energy_final, output ready);
endinterface

// ----- rtl/core/twps_cfg_regs.sv -----
`timescale 1ns / 1ps

module twps_cfg_regs import twps_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    twps_cfg_if.sink cfg,
    output cfg_t  regs
);

    cfg_t regs_reg;
    cfg_t regs_next;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                CFG_BOX_LENGTH:    regs_next.box_length    = cfg.data;
                CFG_TIME_STEP:     regs_next.time_step     = cfg.data;
                CFG_PARTICLE_MASS: regs_next.particle_mass = cfg.data;
                default:           regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.box_length    <= BOX_LENGTH_RESET;
            regs_reg.time_step     <= TIME_STEP_RESET;
            regs_reg.particle_mass <= MASS_RESET;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

// ----- rtl/core/twps_mul.sv -----
`timescale 1ns / 1ps

module twps_mul import twps_pkg::*; (
    input  logic                      clk,
    input  logic [WORD_WIDTH-1:0]     op_a,
    input  logic [WORD_WIDTH-1:0]     op_b,
    output logic [2*WORD_WIDTH-1:0]   prod
);

    logic [2*WORD_WIDTH-1:0] prod_reg;

    assign prod = prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
    end

endmodule

// ----- rtl/core/twps_div.sv -----
`timescale 1ns / 1ps

module twps_div import twps_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [WORD_WIDTH-1:0] num,
    input  logic [WORD_WIDTH-1:0] den,
    output div_res_t              res
);

    localparam int W   = WORD_WIDTH;
    localparam int F   = FRACTION_BITS;
    localparam int DVD = W + F;

    logic                 busy_reg;
    logic                 busy_next;
    logic                 done_reg;
    logic                 done_next;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_CNT_W-1:0] cnt_next;
    logic [DVD-1:0]       dvd_reg;
    logic [W-1:0]         den_reg;
    logic [W-1:0]         rem_reg;
    logic [W-1:0]         quot_reg;
    logic                 ovf_reg;

    logic [W:0]           rem_sh;
    logic [W:0]           diff;
    logic                 qbit;
    logic                 last_step;

    assign res.done = done_reg;
    assign res.ovf  = ovf_reg;
    assign res.quot = quot_reg;

    always_comb
    begin
        rem_sh    = {rem_reg, dvd_reg[DVD-1]};
        diff      = rem_sh - {1'b0, den_reg};
        qbit      = (rem_sh >= {1'b0, den_reg});
        last_step = (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (last_step)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // restoring division, one quotient bit a cycle; carry-out of the word marks overflow
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg  <= {num, {F{1'b0}}};
            den_reg  <= den;
            rem_reg  <= '0;
            quot_reg <= '0;
            ovf_reg  <= 1'b0;
        end
        else if (busy_reg)
        begin
            dvd_reg  <= {dvd_reg[DVD-2:0], 1'b0};
            rem_reg  <= qbit ? diff[W-1:0] : rem_sh[W-1:0];
            quot_reg <= {quot_reg[W-2:0], qbit};
            ovf_reg  <= ovf_reg | quot_reg[W-1];
        end
    end

endmodule

// ----- rtl/core/twps_ctrl.sv -----
`timescale 1ns / 1ps

module twps_ctrl import twps_pkg::*; (
    input  logic                      clk,
    input  logic                      rst_n,
    input  cfg_t                      regs,
    twps_in_if.sink                   particle,
    twps_out_if.source                result,
    output logic [WORD_WIDTH-1:0]     mul_a,
    output logic [WORD_WIDTH-1:0]     mul_b,
    input  logic [2*WORD_WIDTH-1:0]   mul_prod,
    output logic                      div_start,
    output logic [WORD_WIDTH-1:0]     div_num,
    output logic [WORD_WIDTH-1:0]     div_den,
    input  div_res_t                  div_res
);

    localparam int W      = WORD_WIDTH;
    localparam int F      = FRACTION_BITS;
    localparam int XN_W   = 2 * W - F + 1;
    localparam int A_W    = 2 * W - F;
    localparam int PT_W   = 3 * W;
    localparam int TERM_W = PT_W - F - 1;
    localparam int SUM_W  = (TERM_W >= ENERGY_W) ? TERM_W + 1 : ENERGY_W + 1;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_MUL_DX = 4'd1;
    localparam logic [3:0] S_POS    = 4'd2;
    localparam logic [3:0] S_DIV    = 4'd3;
    localparam logic [3:0] S_REM    = 4'd4;
    localparam logic [3:0] S_MUL_VR = 4'd5;
    localparam logic [3:0] S_WALL   = 4'd6;
    localparam logic [3:0] S_MUL_VV = 4'd7;
    localparam logic [3:0] S_SPLIT  = 4'd8;
    localparam logic [3:0] S_MUL_AL = 4'd9;
    localparam logic [3:0] S_MUL_AH = 4'd10;
    localparam logic [3:0] S_SUM    = 4'd11;

    logic [3:0]             state_reg;
    logic [3:0]             state_next;
    logic [ENERGY_W-1:0]    acc_reg;
    logic [ENERGY_W-1:0]    acc_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;

    logic [W-1:0]           x_reg;
    logic [W-1:0]           v_reg;
    logic [W-1:0]           ls_reg;
    logic [W-1:0]           rs_reg;
    logic                   last_reg;
    logic signed [XN_W-1:0] xn_reg;
    logic [W-1:0]           vn_reg;
    logic                   left_reg;
    logic                   right_reg;
    logic [CFG_W-1:0]       rem_reg;
    logic [A_W-1:0]         a_reg;
    logic [2*W-1:0]         pl_reg;

    logic [W-1:0]           xo_reg;
    logic [W-1:0]           vo_reg;
    logic                   hl_reg;
    logic                   hr_reg;
    logic [ENERGY_W-1:0]    eo_reg;
    logic                   ef_reg;

    logic [W-1:0]           vmag;
    logic signed [XN_W-1:0] step;
    logic signed [XN_W-1:0] x_ext;
    logic signed [XN_W-1:0] len_ext;
    logic signed [XN_W-1:0] xn_c;
    logic                   hit_l;
    logic                   hit_r;
    logic signed [W:0]      right_d;
    logic [W-1:0]           rd_mag;
    logic [W-1:0]           ls_mag;
    logic [W-1:0]           vn_l;
    logic [W-1:0]           vn_r;
    logic                   t_sat;
    logic [CFG_W-1:0]       rem_c;
    logic signed [XN_W-1:0] xn_wall;
    logic [PT_W-1:0]        ptot;
    logic [TERM_W-1:0]      term;
    logic [SUM_W-1:0]       esum;
    logic [ENERGY_W-1:0]    esat;
    logic [XN_W-W:0]        xn_hi;
    logic [W-1:0]           xo_c;
    logic                   commit;

    assign particle.ready      = (state_reg == S_IDLE);
    assign result.valid        = out_valid_reg;
    assign result.new_position = xo_reg;
    assign result.new_velocity = vo_reg;
    assign result.hit_left     = hl_reg;
    assign result.hit_right    = hr_reg;
    assign result.energy_total = eo_reg;
    assign result.energy_final = ef_reg;

    always_comb
    begin
        vmag    = mag_f(vn_reg);
        step    = XN_W'(mul_prod[2*W-1:F]);
        x_ext   = {{(XN_W-W){x_reg[W-1]}}, x_reg};
        len_ext = XN_W'(regs.box_length);
        xn_c    = v_reg[W-1] ? (x_ext - step) : (x_ext + step);
        hit_l   = xn_c[XN_W-1] || (xn_c == '0);
        hit_r   = !hit_l && (xn_c >= len_ext);

        right_d = $signed({2'b00, regs.box_length}) - $signed({x_reg[W-1], x_reg});
        rd_mag  = right_d[W] ? W'(-right_d) : right_d[W-1:0];

        ls_mag  = mag_f(ls_reg);
        vn_l    = ls_mag[W-1] ? {1'b0, {(W-1){1'b1}}} : ls_mag;
        vn_r    = (!rs_reg[W-1] && (rs_reg != '0)) ? (~rs_reg + 1'b1) : rs_reg;

        div_start = (state_reg == S_POS) && (hit_l || hit_r);
        div_num   = hit_l ? mag_f(x_reg) : rd_mag;
        div_den   = mag_f(v_reg);

        t_sat   = div_res.ovf || (div_res.quot > W'(regs.time_step));
        rem_c   = t_sat ? '0 : (regs.time_step - div_res.quot[CFG_W-1:0]);

        xn_wall = left_reg ? step : (len_ext - step);

        ptot    = PT_W'(pl_reg) + {mul_prod, {W{1'b0}}};
        term    = ptot[PT_W-1:F+1];
        esum    = SUM_W'(acc_reg) + SUM_W'(term);
        esat    = (esum > SUM_W'(ENERGY_MAX)) ? ENERGY_MAX : esum[ENERGY_W-1:0];

        xn_hi   = xn_reg[XN_W-1:W-1];
        if ((&xn_hi) || !(|xn_hi))
            xo_c = xn_reg[W-1:0];
        else if (xn_reg[XN_W-1])
            xo_c = {1'b1, {(W-1){1'b0}}};
        else
            xo_c = {1'b0, {(W-1){1'b1}}};

        commit = (state_reg == S_SUM) && (!out_valid_reg || result.ready);
    end

    always_comb
    begin
        case (state_reg)
            S_MUL_DX:
            begin
                mul_a = mag_f(v_reg);
                mul_b = W'(regs.time_step);
            end
            S_MUL_VR:
            begin
                mul_a = vmag;
                mul_b = W'(rem_reg);
            end
            S_MUL_VV:
            begin
                mul_a = vmag;
                mul_b = vmag;
            end
            S_MUL_AL:
            begin
                mul_a = a_reg[W-1:0];
                mul_b = W'(regs.particle_mass);
            end
            S_MUL_AH, S_SUM:
            begin
                mul_a = W'(a_reg[A_W-1:W]);
                mul_b = W'(regs.particle_mass);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (particle.valid) state_next = S_MUL_DX;
            S_MUL_DX: state_next = S_POS;
            S_POS:    state_next = (hit_l || hit_r) ? S_DIV : S_MUL_VV;
            S_DIV:    if (div_res.done) state_next = S_REM;
            S_REM:    state_next = S_MUL_VR;
            S_MUL_VR: state_next = S_WALL;
            S_WALL:   state_next = S_MUL_VV;
            S_MUL_VV: state_next = S_SPLIT;
            S_SPLIT:  state_next = S_MUL_AL;
            S_MUL_AL: state_next = S_MUL_AH;
            S_MUL_AH: state_next = S_SUM;
            S_SUM:    if (commit) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase

        acc_next = acc_reg;
        if (commit)
            acc_next = last_reg ? '0 : esat;

        out_valid_next = out_valid_reg;
        if (commit)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (particle.valid)
                begin
                    x_reg    <= particle.old_position;
                    v_reg    <= particle.old_velocity;
                    ls_reg   <= particle.left_sample;
                    rs_reg   <= particle.right_sample;
                    last_reg <= particle.last_particle;
                end
            end
            S_POS:
            begin
                xn_reg    <= xn_c;
                left_reg  <= hit_l;
                right_reg <= hit_r;
                vn_reg    <= hit_l ? vn_l : (hit_r ? vn_r : v_reg);
            end
            S_REM:    rem_reg <= rem_c;
            S_WALL:   xn_reg  <= xn_wall;
            S_SPLIT:  a_reg   <= mul_prod[2*W-1:F];
            S_MUL_AH: pl_reg  <= mul_prod;
            S_SUM:
            begin
                if (commit)
                begin
                    xo_reg <= xo_c;
                    vo_reg <= vn_reg;
                    hl_reg <= left_reg;
                    hr_reg <= right_reg;
                    eo_reg <= esat;
                    ef_reg <= last_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    a_clear_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        commit && last_reg |=> acc_reg == '0)
        else $error("energy sum not cleared after last particle");

    a_one_wall: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> !(result.hit_left && result.hit_right))
        else $error("both walls flagged");

    a_left_inward: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.hit_left |-> !result.new_velocity[W-1])
        else $error("left wall velocity not inward");

    a_right_inward: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.hit_right |->
            (result.new_velocity[W-1] || (result.new_velocity == '0)))
        else $error("right wall velocity not inward");

    a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |=> state_reg == S_DIV)
        else $error("divider started outside the wall path");

endmodule

// ----- rtl/core/thermal_wall_particle_step_top.sv -----
`timescale 1ns / 1ps
// A new particle is taken only once the result of the last one has been committed and the
// sequencer is idle again; the result waits in the sum state while the output is stalled.
// The wall-arrival divider, one quotient bit a cycle over 48 bits, runs only on a wall
// hit; four passes (five on a wall hit) through one shared 32x32 multiplier serve the
// rest. Reset (rst_n low, asynchronous) clears the sequencer, the output valid flag and
// the energy sum, and loads the register defaults.

module thermal_wall_particle_step_top import twps_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    twps_cfg_if.sink   cfg,
    twps_in_if.sink    particle,
    twps_out_if.source result
);

    cfg_t                    regs;
    logic [WORD_WIDTH-1:0]   mul_a;
    logic [WORD_WIDTH-1:0]   mul_b;
    logic [2*WORD_WIDTH-1:0] mul_prod;
    logic                    div_start;
    logic [WORD_WIDTH-1:0]   div_num;
    logic [WORD_WIDTH-1:0]   div_den;
    div_res_t                div_res;

    twps_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    twps_mul u_mul (
        .clk  (clk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (mul_prod)
    );

    twps_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .res   (div_res)
    );

    twps_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .regs      (regs),
        .particle  (particle),
        .result    (result),
        .mul_a     (mul_a),
        .mul_b     (mul_b),
        .mul_prod  (mul_prod),
        .div_start (div_start),
        .div_num   (div_num),
        .div_den   (div_den),
        .div_res   (div_res)
    );

endmodule
